[sv/lfa_pkg.sv]
// ----------------------------------------------------------------------------
// lfa_pkg
// Shared types and constants for the lazy-fill counter array.
// ----------------------------------------------------------------------------
package lfa_pkg;

    localparam int IDX_BITS       = 10;
    localparam int VAL_BITS       = 32;
    localparam int OUT_BITS       = 48;
    localparam int TAG_BITS       = 8;
    localparam int DEPTH_DEF      = 1024;
    localparam int ENTRY_BITS_DEF = 48;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_FILL = 2'd1,
        ACT_ADD  = 2'd2,
        ACT_READ = 2'd3
    } action_t;

    // fill state seen by the update logic
    typedef struct packed {
        logic                fill_active;
        logic [TAG_BITS-1:0] cur;
        logic [VAL_BITS-1:0] fill_value;
    } epoch_t;

endpackage

[sv/lazy_fill_array.sv]
// ----------------------------------------------------------------------------
// lazy_fill_array
// Table of saturating counters with a lazy whole-table fill.
//
// Requests: action/index/value are taken at a clock edge with start high and
// busy low. Load, add and read are read-modify-write on one RAM whose words
// hold the entry and an epoch tag; a fill bumps the epoch, so every entry
// goes stale at once and takes the fill value on its next touch.
// Throughput: one request per cycle while busy is low. The RAM read goes
// out at accept and the write-back happens the next cycle; back-to-back
// hits on one entry are forwarded from the write-back stage.
// A read returns read_value with done high for one cycle; the request is
// registered in the s1 stage, then done and read_value are registered.
// Other actions give no result. Each 255th fill (and the first one after
// reset) wraps the epoch; busy stays high while a sweep clears every tag.
// Reset: fill mode off, epoch at its wrap value; RAM contents are left as is.
// The result has no back-pressure: done/read_value must be taken when shown.
// ----------------------------------------------------------------------------
module lazy_fill_array
    import lfa_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ENTRY_BITS = ENTRY_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          action,
    input  logic [IDX_BITS-1:0] index,
    input  logic [VAL_BITS-1:0] value,
    output logic                busy,
    output logic                done,
    output logic [OUT_BITS-1:0] read_value
);

    localparam int AW = $clog2(DEPTH);
    localparam int WW = ENTRY_BITS + TAG_BITS;
    localparam int XW = (AW > IDX_BITS) ? AW : IDX_BITS;

    logic                  accept;
    logic [XW-1:0]         idx_ext;
    logic [AW-1:0]         addr;
    logic                  in_ok;

    logic                  s1_valid_reg;
    action_t               s1_act_reg;
    logic                  s1_ok_reg;
    logic [AW-1:0]         s1_addr_reg;
    logic [VAL_BITS-1:0]   s1_value_reg;
    logic                  fwd_hit_reg;
    logic                  fwd_hit_next;
    logic [WW-1:0]         fwd_word_reg;

    logic                  done_reg;
    logic [OUT_BITS-1:0]   read_value_reg;

    logic [WW-1:0]         ram_rdata;
    logic [WW-1:0]         cur_word;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WW-1:0]         ram_wdata;

    epoch_t                ep;
    logic                  hold;
    logic                  fill_req;
    logic                  sweep_we;
    logic [AW-1:0]         sweep_addr;

    logic                  upd_we;
    logic [WW-1:0]         upd_word;
    logic [ENTRY_BITS-1:0] upd_entry;

    assign busy    = hold;
    assign accept  = start & ~busy;
    assign idx_ext = XW'(index);
    assign addr    = idx_ext[AW-1:0];
    assign in_ok   = (32'(index) < 32'(DEPTH));

    assign fill_req = s1_valid_reg & (s1_act_reg == ACT_FILL);
    assign cur_word = fwd_hit_reg ? fwd_word_reg : ram_rdata;

    assign ram_we    = sweep_we | upd_we;
    assign ram_waddr = sweep_we ? sweep_addr : s1_addr_reg;
    assign ram_wdata = sweep_we ? '0 : upd_word;

    assign fwd_hit_next = accept & upd_we & (addr == s1_addr_reg);

    lfa_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    lfa_epoch #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_epoch (
        .clk        (clk),
        .rst_n      (rst_n),
        .fill_req   (fill_req),
        .fill_value (s1_value_reg),
        .ep         (ep),
        .hold       (hold),
        .sweep_we   (sweep_we),
        .sweep_addr (sweep_addr)
    );

    lfa_update #(
        .ENTRY_BITS (ENTRY_BITS),
        .WW         (WW)
    ) u_update (
        .valid    (s1_valid_reg),
        .act      (s1_act_reg),
        .ok       (s1_ok_reg),
        .value    (s1_value_reg),
        .word     (cur_word),
        .ep       (ep),
        .wr_en    (upd_we),
        .wr_word  (upd_word),
        .rd_entry (upd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            fwd_hit_reg  <= fwd_hit_next;
            done_reg     <= s1_valid_reg & (s1_act_reg == ACT_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_act_reg   <= action_t'(action);
            s1_ok_reg    <= in_ok;
            s1_addr_reg  <= addr;
            s1_value_reg <= value;
        end
        fwd_word_reg   <= upd_word;
        read_value_reg <= s1_ok_reg ? OUT_BITS'(upd_entry) : '0;
    end

    assign done       = done_reg;
    assign read_value = read_value_reg;

endmodule

[sv/lfa_ram.sv]
// ----------------------------------------------------------------------------
// lfa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/lfa_epoch.sv]
// ----------------------------------------------------------------------------
// lfa_epoch
// Fill value, fill mode and epoch counter. An entry is fresh when its stored
// tag equals the current epoch. When the epoch wraps, a sweep writes tag zero
// to every entry, one per cycle.
// ----------------------------------------------------------------------------
module lfa_epoch
    import lfa_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fill_req,
    input  logic [VAL_BITS-1:0] fill_value,
    output epoch_t              ep,
    output logic                hold,
    output logic                sweep_we,
    output logic [AW-1:0]       sweep_addr
);

    logic                fill_active_reg;
    logic [TAG_BITS-1:0] cur_reg;
    logic [VAL_BITS-1:0] fill_value_reg;
    logic                sweep_reg;
    logic [AW-1:0]       cnt_reg;
    logic                wrap;

    assign wrap = (cur_reg == {TAG_BITS{1'b1}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_active_reg <= 1'b0;
            cur_reg         <= {TAG_BITS{1'b1}};
            fill_value_reg  <= '0;
            sweep_reg       <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            if (fill_req)
            begin
                fill_value_reg  <= fill_value;
                fill_active_reg <= 1'b1;
                if (wrap)
                begin
                    cur_reg   <= TAG_BITS'(1);
                    sweep_reg <= 1'b1;
                    cnt_reg   <= '0;
                end
                else
                begin
                    cur_reg <= cur_reg + TAG_BITS'(1);
                end
            end
            else if (sweep_reg)
            begin
                cnt_reg <= cnt_reg + AW'(1);
                if (cnt_reg == AW'(DEPTH - 1))
                begin
                    sweep_reg <= 1'b0;
                end
            end
        end
    end

    assign ep.fill_active = fill_active_reg;
    assign ep.cur         = cur_reg;
    assign ep.fill_value  = fill_value_reg;
    assign hold           = sweep_reg | (fill_req & wrap);
    assign sweep_we       = sweep_reg;
    assign sweep_addr     = cnt_reg;

endmodule

[sv/lfa_update.sv]
// ----------------------------------------------------------------------------
// lfa_update
// Read-modify-write datapath: resolves a pending fill, applies the request
// and builds the word written back.
// ----------------------------------------------------------------------------
module lfa_update
    import lfa_pkg::*;
#(
    parameter int ENTRY_BITS = ENTRY_BITS_DEF,
    parameter int WW         = ENTRY_BITS + TAG_BITS
) (
    input  logic                  valid,
    input  action_t               act,
    input  logic                  ok,
    input  logic [VAL_BITS-1:0]   value,
    input  logic [WW-1:0]         word,
    input  epoch_t                ep,
    output logic                  wr_en,
    output logic [WW-1:0]         wr_word,
    output logic [ENTRY_BITS-1:0] rd_entry
);

    logic [TAG_BITS-1:0]   tag;
    logic [ENTRY_BITS-1:0] entry;
    logic                  stale;
    logic [ENTRY_BITS-1:0] base;
    logic [ENTRY_BITS:0]   sum;
    logic [ENTRY_BITS-1:0] sat;
    logic [ENTRY_BITS-1:0] new_entry;
    logic                  writes;

    assign tag   = word[WW-1 -: TAG_BITS];
    assign entry = word[ENTRY_BITS-1:0];
    assign stale = ep.fill_active && (tag != ep.cur);
    assign base  = stale ? ENTRY_BITS'(ep.fill_value) : entry;
    assign sum   = {1'b0, base} + (ENTRY_BITS + 1)'(value);
    assign sat   = sum[ENTRY_BITS] ? {ENTRY_BITS{1'b1}} : sum[ENTRY_BITS-1:0];

    always_comb
    begin
        case (act)
            ACT_LOAD:
            begin
                new_entry = ENTRY_BITS'(value);
                writes    = 1'b1;
            end
            ACT_ADD:
            begin
                new_entry = sat;
                writes    = 1'b1;
            end
            ACT_READ:
            begin
                new_entry = base;
                writes    = 1'b1;
            end
            default:
            begin
                new_entry = base;
                writes    = 1'b0;
            end
        endcase
    end

    assign wr_en    = valid & ok & writes;
    assign wr_word  = {ep.cur, new_entry};
    assign rd_entry = base;

endmodule

[sv/lfa_checker.sv]
// ----------------------------------------------------------------------------
// lfa_checker
// Port-level checks on request/result timing, bound to lazy_fill_array.
// ----------------------------------------------------------------------------
module lfa_checker
    import lfa_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic [1:0]          action,
    input logic [IDX_BITS-1:0] index,
    input logic                busy,
    input logic                done,
    input logic [OUT_BITS-1:0] read_value
);

    logic acc_read;
    logic acc_other;

    assign acc_read  = start && !busy && (action == ACT_READ);
    assign acc_other = start && !busy && (action != ACT_READ);

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        acc_read |-> ##2 done)
        else $error("read request without result");

    a_other_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        acc_other |-> ##2 !done)
        else $error("result for a non-read request");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(acc_read, 2))
        else $error("result without a read request");

    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_read && (32'(index) >= 32'(DEPTH))) |-> ##2 (read_value == '0))
        else $error("out-of-range read not zero");

endmodule

bind lazy_fill_array lfa_checker #(.DEPTH(DEPTH)) u_lfa_checker (.*);

[tb/lazy_fill_array_tb.sv]
// ----------------------------------------------------------------------------
// lazy_fill_array_tb
// Self-checking bench for the lazy-fill counter array. Requests are driven
// on the falling edge and taken on start high with busy low. A predictor in
// the bench keeps its own copy of the table, fresh marks and fill state, and
// queues the value that each read must return. A checker compares every done
// strobe with the oldest queued read. Directed tests cover load/read before
// any fill, the fill path, add chains that carry past 32 bits and epoch wrap.
// Random traffic follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lazy_fill_array_tb;
    import lfa_pkg::*;

    localparam int                 ENTRY_W      = ENTRY_BITS_DEF;
    localparam int                 N_ENTRY      = DEPTH_DEF;
    localparam logic [ENTRY_W-1:0] ENTRY_MAX    = '1;
    localparam logic [VAL_BITS-1:0] VAL_MAX     = '1;
    localparam int                 LIMIT_CYCLES = 1_000_000;
    localparam int                 CHAIN_ADDS   = 16;
    localparam int                 WRAP_FILLS   = 260;
    localparam int                 RAND_ITEMS   = 746;
    localparam int                 RAND_GAPPED  = 600;

    logic                clk   = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [1:0]          action = ACT_LOAD;
    logic [IDX_BITS-1:0] index  = '0;
    logic [VAL_BITS-1:0] value  = '0;
    logic                busy;
    logic                done;
    logic [OUT_BITS-1:0] read_value;

    // predicted table state
    logic [ENTRY_W-1:0]  cnt_mem   [N_ENTRY];
    bit                  fresh_mem [N_ENTRY];
    logic [VAL_BITS-1:0] fill_val_m = '0;
    bit                  fill_on_m  = 1'b0;

    logic [OUT_BITS-1:0] pending_reads [$];
    logic [OUT_BITS-1:0] want_value;
    int                  err_count = 0;
    int                  cycle_cnt = 0;
    bit                  gaps_on   = 1'b1;

    lazy_fill_array u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .action     (action),
        .index      (index),
        .value      (value),
        .busy       (busy),
        .done       (done),
        .read_value (read_value)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [ENTRY_W-1:0] sat_sum(logic [ENTRY_W-1:0] a,
                                                   logic [VAL_BITS-1:0] b);
        logic [ENTRY_W:0] s;
        s = {1'b0, a} + {{(ENTRY_W + 1 - VAL_BITS){1'b0}}, b};
        return s[ENTRY_W] ? ENTRY_MAX : s[ENTRY_W-1:0];
    endfunction

    task automatic apply_counter_op(action_t act, logic [IDX_BITS-1:0] idx,
                                    logic [VAL_BITS-1:0] val);
        case (act)
            ACT_LOAD:
            begin
                cnt_mem[idx]   = ENTRY_W'(val);
                fresh_mem[idx] = 1'b1;
            end
            ACT_FILL:
            begin
                fill_val_m = val;
                fill_on_m  = 1'b1;
                foreach (fresh_mem[i]) fresh_mem[i] = 1'b0;
            end
            ACT_ADD:
            begin
                if (fill_on_m && !fresh_mem[idx])
                begin
                    cnt_mem[idx]   = sat_sum(ENTRY_W'(fill_val_m), val);
                    fresh_mem[idx] = 1'b1;
                end
                else
                begin
                    cnt_mem[idx] = sat_sum(cnt_mem[idx], val);
                end
            end
            default:
            begin
                if (fill_on_m && !fresh_mem[idx])
                begin
                    cnt_mem[idx]   = ENTRY_W'(fill_val_m);
                    fresh_mem[idx] = 1'b1;
                end
                pending_reads.push_back(OUT_BITS'(cnt_mem[idx]));
            end
        endcase
    endtask

    task automatic idle_for(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // one request: hold start until the block takes it
    task automatic send_request(action_t act, logic [IDX_BITS-1:0] idx,
                                logic [VAL_BITS-1:0] val);
        if (gaps_on && $urandom_range(0, 4) == 0)
            idle_for($urandom_range(1, 11));
        @(negedge clk);
        start  <= 1'b1;
        action <= act;
        index  <= idx;
        value  <= val;
        @(posedge clk);
        while (busy) @(posedge clk);
        apply_counter_op(act, idx, val);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_reads.size() != 0) @(negedge clk);
    endtask

    function automatic logic [IDX_BITS-1:0] pick_index();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return IDX_BITS'($urandom_range(0, 7));
        else if (r < 8)
            return IDX_BITS'(N_ENTRY - 1 - $urandom_range(0, 3));
        return IDX_BITS'($urandom_range(0, N_ENTRY - 1));
    endfunction

    function automatic logic [VAL_BITS-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return VAL_MAX;
        return VAL_BITS'($urandom());
    endfunction

    function automatic action_t pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return ACT_FILL;
        else if (r < 28)
            return ACT_LOAD;
        else if (r < 62)
            return ACT_ADD;
        return ACT_READ;
    endfunction

    // fill mode is off here: only loaded entries are added to or read
    task automatic test_load_read();
        send_request(ACT_LOAD, 10'd0, '0);
        send_request(ACT_LOAD, 10'd1023, VAL_MAX);
        send_request(ACT_LOAD, 10'd5, 32'h1234_5678);
        send_request(ACT_READ, 10'd0, 32'h5555_AAAA);
        send_request(ACT_READ, 10'd1023, '0);
        send_request(ACT_ADD, 10'd5, 32'h0000_0001);
        send_request(ACT_READ, 10'd5, '0);
        send_request(ACT_ADD, 10'd1023, VAL_MAX);
        send_request(ACT_READ, 10'd1023, '0);
        send_request(ACT_LOAD, 10'd0, 32'hA5A5_5A5A);
        send_request(ACT_READ, 10'd0, '0);
        wait_drained();
    endtask

    task automatic test_fill();
        send_request(ACT_FILL, 10'd0, 32'd7);
        send_request(ACT_READ, 10'd0, '0);
        send_request(ACT_ADD, 10'd5, 32'd3);
        send_request(ACT_READ, 10'd5, '0);
        send_request(ACT_LOAD, 10'd1023, 32'd100);
        send_request(ACT_FILL, 10'd1023, VAL_MAX);
        send_request(ACT_ADD, 10'd1023, VAL_MAX);
        send_request(ACT_READ, 10'd1023, '0);
        send_request(ACT_READ, 10'd200, '0);
        send_request(ACT_FILL, 10'd512, '0);
        send_request(ACT_READ, 10'd5, '0);
        send_request(ACT_ADD, 10'd0, 32'd1);
        send_request(ACT_READ, 10'd0, '0);
        wait_drained();
    endtask

    // back-to-back adds on one entry, carrying well past 32 bits
    task automatic test_add_chain();
        gaps_on = 1'b0;
        send_request(ACT_LOAD, 10'd9, VAL_MAX);
        for (int i = 0; i < CHAIN_ADDS; i++)
        begin
            send_request(ACT_ADD, 10'd9, VAL_MAX);
            if (i % 4 == 0 || i >= CHAIN_ADDS - 6)
                send_request(ACT_READ, 10'd9, '0);
        end
        send_request(ACT_ADD, 10'd9, 32'd1);
        send_request(ACT_READ, 10'd9, '0);
        wait_drained();
        gaps_on = 1'b1;
    endtask

    // enough fills to wrap the epoch; entry 300 is read back at the end
    task automatic test_fill_wrap();
        send_request(ACT_LOAD, 10'd300, 32'h0000_DEAD);
        for (int i = 0; i < WRAP_FILLS; i++)
        begin
            send_request(ACT_FILL, pick_index(), pick_value());
            repeat ($urandom_range(1, 2))
                send_request(action_t'($urandom_range(ACT_LOAD, ACT_READ)),
                             pick_index(), pick_value());
            if (i == WRAP_FILLS / 2)
                wait_drained();
        end
        send_request(ACT_READ, 10'd300, '0);
        wait_drained();
    endtask

    task automatic test_random();
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            gaps_on = (n < RAND_GAPPED);
            send_request(pick_action(), pick_index(), pick_value());
            if (n % 300 == 150)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_load_read();
        test_fill();
        test_add_chain();
        test_fill_wrap();
        test_random();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("PASS lazy_fill_array");
        else
            $display("FAIL lazy_fill_array");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_reads.size() == 0)
            begin
                $display("%0t: read_value with no read pending: expected none actual %h",
                         $time, read_value);
                err_count++;
            end
            else
            begin
                want_value = pending_reads.pop_front();
                if (read_value !== want_value)
                begin
                    $display("%0t: read_value mismatch: expected %h actual %h",
                             $time, want_value, read_value);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("FAIL lazy_fill_array");
            $finish;
        end
    end

endmodule
